// ----- rtl/lptcr_pkg.sv -----
// ----------------------------------------------------------------------------
// lptcr_pkg
// Shared types and constants of the low-power timer with compare and reload.
// ----------------------------------------------------------------------------
package lptcr_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int PRESCALE_BITS = 3;
    // Widest prescaler limit is 2**(2**PRESCALE_BITS - 1) - 1.
    localparam int PSC_W         = (1 << PRESCALE_BITS) - 1;
    localparam int FLAG_W        = 9;
    localparam int CTL_W         = 3;
    localparam int CFG_SHIFT     = 9;
    localparam int DATA_W        = 32;
    localparam int ACT_W         = 2;
    localparam int IDX_W         = 4;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_STATUS  = 4'd0;
    localparam logic [IDX_W-1:0] REG_CLEAR   = 4'd1;
    localparam logic [IDX_W-1:0] REG_ENABLE  = 4'd2;
    localparam logic [IDX_W-1:0] REG_CFG     = 4'd3;
    localparam logic [IDX_W-1:0] REG_CONTROL = 4'd4;
    localparam logic [IDX_W-1:0] REG_COMPARE = 4'd5;
    localparam logic [IDX_W-1:0] REG_RELOAD  = 4'd6;
    localparam logic [IDX_W-1:0] REG_COUNT   = 4'd7;

    // Status bits.
    localparam int F_CMP   = 0;
    localparam int F_OVF   = 1;
    localparam int F_CMPOK = 3;
    localparam int F_RLDOK = 4;

    // Control bits.
    localparam int CTL_EN   = 0;
    localparam int CTL_CONT = 2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [IDX_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } t_res;

endpackage

// ----- rtl/lptcr_core.sv -----
// ----------------------------------------------------------------------------
// lptcr_core
// Timer register file, prescaler and counter; one item per cycle of i_fire.
// ----------------------------------------------------------------------------
module lptcr_core
    import lptcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_cmd i_cmd,
    output t_res o_res
);

    logic [COUNT_WIDTH-1:0]   r_count,   n_count;
    logic [COUNT_WIDTH-1:0]   r_reload,  n_reload;
    logic [COUNT_WIDTH-1:0]   r_compare, n_compare;
    logic [FLAG_W-1:0]        r_status,  n_status;
    logic [FLAG_W-1:0]        r_enable,  n_enable;
    logic [PRESCALE_BITS-1:0] r_sel,     n_sel;
    logic [CTL_W-1:0]         r_ctl,     n_ctl;
    logic [PSC_W-1:0]         r_psc,     n_psc;

    logic [PSC_W-1:0]         w_limit;
    logic [COUNT_WIDTH-1:0]   w_step_count;
    logic [DATA_W-1:0]        w_rd;

    assign w_limit = (PSC_W'(1) << r_sel) - PSC_W'(1);
    // A count at or above the reload wraps to zero.
    assign w_step_count = (r_count >= r_reload) ? '0 : r_count + COUNT_WIDTH'(1);

    always_comb begin
        n_count   = r_count;
        n_reload  = r_reload;
        n_compare = r_compare;
        n_status  = r_status;
        n_enable  = r_enable;
        n_sel     = r_sel;
        n_ctl     = r_ctl;
        n_psc     = r_psc;
        w_rd      = '0;
        unique case (i_cmd.action)
            ACT_TICK: begin
                if (r_ctl[CTL_EN] && r_ctl[CTL_CONT]) begin
                    if (r_psc >= w_limit) begin
                        n_psc   = '0;
                        n_count = w_step_count;
                        if (r_count >= r_reload) n_status[F_OVF] = 1'b1;
                        if (w_step_count == r_compare) n_status[F_CMP] = 1'b1;
                    end else begin
                        n_psc = r_psc + PSC_W'(1);
                    end
                end
            end
            ACT_READ: begin
                unique case (i_cmd.reg_index)
                    REG_STATUS:  w_rd = DATA_W'(r_status);
                    REG_ENABLE:  w_rd = DATA_W'(r_enable);
                    REG_CFG:     w_rd = DATA_W'(r_sel) << CFG_SHIFT;
                    REG_CONTROL: w_rd = DATA_W'(r_ctl);
                    REG_COMPARE: w_rd = DATA_W'(r_compare);
                    REG_RELOAD:  w_rd = DATA_W'(r_reload);
                    REG_COUNT:   w_rd = DATA_W'(r_count);
                    default:     w_rd = '0;
                endcase
            end
            ACT_WRITE: begin
                unique case (i_cmd.reg_index)
                    REG_CLEAR:  n_status = r_status & ~i_cmd.write_data[FLAG_W-1:0];
                    REG_ENABLE: n_enable = i_cmd.write_data[FLAG_W-1:0];
                    REG_CFG:    n_sel = i_cmd.write_data[CFG_SHIFT +: PRESCALE_BITS];
                    REG_CONTROL: begin
                        n_ctl = i_cmd.write_data[CTL_W-1:0];
                        if (!i_cmd.write_data[CTL_EN]) begin
                            n_count = '0;
                            n_psc   = '0;
                        end
                    end
                    REG_COMPARE: begin
                        n_compare         = i_cmd.write_data[COUNT_WIDTH-1:0];
                        n_status[F_CMPOK] = 1'b1;
                    end
                    REG_RELOAD: begin
                        n_reload          = i_cmd.write_data[COUNT_WIDTH-1:0];
                        n_status[F_RLDOK] = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            // The unused action code changes nothing.
            default: begin
            end
        endcase
    end

    assign o_res.read_data = w_rd;
    assign o_res.irq       = |(n_status & n_enable);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_reload  <= COUNT_WIDTH'(1);
            r_compare <= '0;
            r_status  <= '0;
            r_enable  <= '0;
            r_sel     <= '0;
            r_ctl     <= '0;
            r_psc     <= '0;
        end else if (i_fire) begin
            r_count   <= n_count;
            r_reload  <= n_reload;
            r_compare <= n_compare;
            r_status  <= n_status;
            r_enable  <= n_enable;
            r_sel     <= n_sel;
            r_ctl     <= n_ctl;
            r_psc     <= n_psc;
        end
    end

endmodule

// ----- rtl/low_power_timer_compare_reload.sv -----
// ----------------------------------------------------------------------------
// low_power_timer_compare_reload
// Low-power timer with prescaler, auto-reload and compare, driven by items.
// ----------------------------------------------------------------------------
// Each input item is a clock tick, a register read or a register write
// (i_action, i_reg_index, i_write_data), taken when i_valid is high and
// o_stall is low. Each item produces exactly one result item (o_read_data,
// o_irq), delivered when o_valid is high and i_stall is low. o_read_data
// holds the register value for reads and zero otherwise; o_irq is the state
// of the interrupt line after the item.
// An item is captured in an input register, executed against the timer
// registers when it advances and lands in the output register; one item is
// accepted in every cycle in which o_stall is low.
// When the receiver stalls, the result held in the output register stays
// stable; one more item may wait in the input register, after which o_stall
// rises until the result is taken.
// Reset clears both pipeline registers and puts the timer in its disabled,
// stopped state with reload one and all flags clear.
// ----------------------------------------------------------------------------
module low_power_timer_compare_reload
    import lptcr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [IDX_W-1:0]  i_reg_index,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq
);

    logic r_in_valid;
    t_cmd r_in_cmd;
    logic r_out_valid;
    t_res r_out_res;
    t_res w_res;
    logic w_adv;

    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    lptcr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_cmd   (r_in_cmd),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_cmd.action     <= i_action;
            r_in_cmd.reg_index  <= i_reg_index;
            r_in_cmd.write_data <= i_write_data;
        end
        if (w_adv) begin
            r_out_res <= w_res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_res.read_data;
    assign o_irq       = r_out_res.irq;

endmodule

// ----- rtl/lptcr_checker.sv -----
// ----------------------------------------------------------------------------
// lptcr_checker
// Port-level checks of the timer's pipeline flow, bound to the top level.
// ----------------------------------------------------------------------------
module lptcr_checker
    import lptcr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [ACT_W-1:0]  i_action,
    input logic [IDX_W-1:0]  i_reg_index,
    input logic [DATA_W-1:0] i_write_data,
    input logic              o_valid,
    input logic              i_stall,
    input logic [DATA_W-1:0] o_read_data,
    input logic              o_irq
);

    // The input side only backs up when a result is waiting on a stalled receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // An accepted item reaches the output through both registers when nothing stalls.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall |-> ##1 o_valid)
        else $error("result missing two cycles after an item");

    // No result is offered in the first cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result offered right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_read_data) && $stable(o_irq)))
        else $error("stalled result changed");

    // A stalled input item stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=>
            (i_valid && $stable({i_action, i_reg_index, i_write_data})))
        else $error("stalled input item changed");

endmodule

bind low_power_timer_compare_reload lptcr_checker u_lptcr_checker (.*);
